FILE: hdl/dti_pkg.sv
// Shared types and default sizes for the decision tree inference block.
package dti_pkg;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int FEATURE_COUNT_DEF = 32;
   localparam int OUTPUT_MAX_DEF    = 8;
   localparam int MAX_STEPS_DEF     = 64;

   localparam int NODE_REG_W = 11;

   localparam logic [1:0] OP_WR_FEATURE = 2'd0;
   localparam logic [1:0] OP_WR_NODE    = 2'd1;
   localparam logic [1:0] OP_WR_LEAF    = 2'd2;
   localparam logic [1:0] OP_CLASSIFY   = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [9:0]         node_addr;
      logic [9:0]         child_index;
      logic [4:0]         feature_sel;
      logic signed [15:0] value;
      logic [2:0]         out_sel;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic [2:0]         out_index;
      logic [9:0]         leaf_node;
      logic               last;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic [9:0]         child;
      logic [4:0]         feature;
      logic signed [15:0] threshold;
   } node_type;

endpackage

FILE: hdl/decision_tree_inference_top.sv
// Decision tree inference engine: node, leaf and feature stores with a tree walker.
//
// Write items (feature, node, leaf value) are stored as they are accepted, and the next item
// can be taken straight after. A classify item walks the tree from node 0, passing inner
// nodes and then emitting the leaf values, and the result side may stall it. Each inner
// node costs a node store read, a feature store read and a compare, and each leaf value a
// leaf store read, all through synchronous memories in series. A walk that exceeds
// MAX_STEPS decisions or leaves the node store ends in a single item with error set. No new
// item is taken while a walk runs.
module decision_tree_inference_top #(
   parameter int NODE_COUNT    = dti_pkg::NODE_COUNT_DEF,
   parameter int FEATURE_COUNT = dti_pkg::FEATURE_COUNT_DEF,
   parameter int OUTPUT_MAX    = dti_pkg::OUTPUT_MAX_DEF,
   parameter int MAX_STEPS     = dti_pkg::MAX_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dti_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data
);
   import dti_pkg::*;

   localparam int NIW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int FIW        = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int LEAF_DEPTH = NODE_COUNT * OUTPUT_MAX;
   localparam int LAW        = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
   localparam int KW         = (OUTPUT_MAX > 1) ? $clog2(OUTPUT_MAX) : 1;
   localparam int SW         = $clog2(MAX_STEPS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NODE = 3'd1;
   localparam logic [2:0] S_FEAT = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_ERR  = 3'd4;
   localparam logic [2:0] S_LRD  = 3'd5;
   localparam logic [2:0] S_LOUT = 3'd6;

   node_type           node_mem_ff [NODE_COUNT];
   logic signed [15:0] feat_mem_ff [FEATURE_COUNT];
   logic signed [15:0] leaf_mem_ff [LEAF_DEPTH];

   node_type           node_rd_ff;
   logic signed [15:0] feat_rd_ff;
   logic signed [15:0] leaf_rd_ff;

   logic [2:0]            state_ff, state_in;
   logic [NODE_REG_W-1:0] node_ff, node_in;
   logic [SW-1:0]         steps_ff, steps_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  feat_ok_ff, feat_ok_in;
   logic [3:0]            output_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  node_we, feat_we, leaf_we;
   logic                  node_re, feat_re, leaf_re;
   logic [31:0]           node_waddr_wide, node_raddr_wide;
   logic [31:0]           feat_waddr_wide, feat_raddr_wide;
   logic [31:0]           leaf_waddr_wide, leaf_raddr_wide;
   logic [31:0]           next_wide;
   logic [NODE_REG_W-1:0] next_node;
   logic signed [15:0]    feat_val;
   logic [3:0]            cnt_eff;
   logic                  is_last;
   node_type              node_wdata;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign node_waddr_wide = 32'(req_data.node_addr);
   assign feat_waddr_wide = 32'(req_data.feature_sel);
   assign leaf_waddr_wide = 32'(req_data.node_addr) * OUTPUT_MAX + 32'(req_data.out_sel);
   assign node_raddr_wide = 32'(node_ff);
   assign feat_raddr_wide = 32'(node_rd_ff.feature);
   assign leaf_raddr_wide = 32'(node_ff) * OUTPUT_MAX + 32'(k_ff);

   assign node_we = req_accept && (req_data.op == OP_WR_NODE) && (node_waddr_wide < NODE_COUNT);
   assign feat_we = req_accept && (req_data.op == OP_WR_FEATURE) &&
                    (feat_waddr_wide < FEATURE_COUNT);
   assign leaf_we = req_accept && (req_data.op == OP_WR_LEAF) &&
                    (node_waddr_wide < NODE_COUNT) && (32'(req_data.out_sel) < OUTPUT_MAX);

   assign node_wdata.child     = req_data.child_index;
   assign node_wdata.feature   = req_data.feature_sel;
   assign node_wdata.threshold = req_data.value;

   assign node_re = (state_ff == S_NODE);
   assign feat_re = (state_ff == S_FEAT);
   assign leaf_re = (state_ff == S_LRD);

   assign feat_val  = feat_ok_ff ? feat_rd_ff : 16'sd0;
   assign next_node = {1'b0, node_rd_ff.child} +
                      NODE_REG_W'(!(feat_val < node_rd_ff.threshold));
   assign next_wide = 32'(next_node);
   assign is_last   = ((4'(k_ff) + 4'd1) == cnt_ff);

   always_comb begin
      if (output_count_ff == 4'd0) begin
         cnt_eff = 4'd1;
      end else if (32'(output_count_ff) > OUTPUT_MAX) begin
         cnt_eff = 4'(OUTPUT_MAX);
      end else begin
         cnt_eff = output_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem_ff[node_waddr_wide[NIW-1:0]] <= node_wdata;
      end
      if (node_re) begin
         node_rd_ff <= node_mem_ff[node_raddr_wide[NIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem_ff[feat_waddr_wide[FIW-1:0]] <= req_data.value;
      end
      if (feat_re) begin
         feat_rd_ff <= feat_mem_ff[feat_raddr_wide[FIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem_ff[leaf_waddr_wide[LAW-1:0]] <= req_data.value;
      end
      if (leaf_re) begin
         leaf_rd_ff <= leaf_mem_ff[leaf_raddr_wide[LAW-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      feat_ok_in   = feat_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.op == OP_CLASSIFY)) begin
               node_in  = '0;
               steps_in = '0;
               k_in     = '0;
               cnt_in   = cnt_eff;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            state_in = S_FEAT;
         end
         S_FEAT: begin
            if (node_rd_ff.child == 10'd0) begin
               state_in = S_LRD;
            end else if (steps_ff >= SW'(MAX_STEPS)) begin
               state_in = S_ERR;
            end else begin
               feat_ok_in = (feat_raddr_wide < FEATURE_COUNT);
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (next_wide >= NODE_COUNT) begin
               state_in = S_ERR;
            end else begin
               node_in  = next_node;
               steps_in = steps_ff + SW'(1);
               state_in = S_NODE;
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_value = 16'sd0;
               rsp_data_in.out_index = 3'd0;
               rsp_data_in.leaf_node = node_ff[9:0];
               rsp_data_in.last      = 1'b1;
               rsp_data_in.error     = 1'b1;
               state_in              = S_IDLE;
            end
         end
         S_LRD: begin
            state_in = S_LOUT;
         end
         S_LOUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_value = leaf_rd_ff;
               rsp_data_in.out_index = 3'(k_ff);
               rsp_data_in.leaf_node = node_ff[9:0];
               rsp_data_in.last      = is_last;
               rsp_data_in.error     = 1'b0;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_LRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         node_ff         <= '0;
         steps_ff        <= '0;
         k_ff            <= '0;
         cnt_ff          <= 4'd1;
         feat_ok_ff      <= 1'b0;
         output_count_ff <= 4'd1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         steps_ff     <= steps_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         feat_ok_ff   <= feat_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            output_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |-> (rsp_data.last && (rsp_data.out_value == 16'sd0) &&
                                        (rsp_data.out_index == 3'd0)))
      else $error("Error item is not a final zero item.");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      (steps_ff <= SW'(MAX_STEPS)))
      else $error("Walk step counter passed its limit.");

   a_walk_ends_with_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != S_IDLE) && (state_in == S_IDLE)) |=> (rsp_valid && rsp_data.last))
      else $error("Walk ended without a final item.");

   a_index_in_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOUT) |-> ((4'(k_ff) < cnt_ff) && (32'(cnt_ff) <= OUTPUT_MAX)))
      else $error("Leaf element index beyond output count.");

endmodule
